// ===== rtl/fptw_pkg.sv =====
package fptw_pkg;

  // field and register widths
  localparam int CFG_W   = 19;
  localparam int MAXT_W  = 5;
  localparam int FUNC_W  = 2;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int OFS_W   = 12;
  localparam int IDX_W   = 9;
  localparam int FRAME_W = PA_W - OFS_W;
  localparam int ROOT_W  = CFG_W - OFS_W;
  localparam int CIDX_W  = 2;

  // entry flag bits
  localparam int PRESENT_BIT  = 0;
  localparam int WRITABLE_BIT = 1;
  localparam logic [OFS_W-1:0] ENTRY_FLAGS =
      OFS_W'((1 << PRESENT_BIT) | (1 << WRITABLE_BIT));

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ROOT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_POOL = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAXT = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_TRANSLATE = 2'd0,
    FN_MAP       = 2'd1,
    FN_UNMAP     = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_TABLE  = 2'd1,
    ST_NO_PAGE   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  // datapath actions, one per control word
  typedef enum logic [3:0] {
    A_NOP,
    A_INIT,
    A_READ,
    A_ADVANCE,
    A_SET_ADDR,
    A_WRITE_ZERO,
    A_WRITE_LEAF,
    A_ALLOC,
    A_SET_EXH,
    A_SET_NT,
    A_SET_NP,
    A_FINISH
  } act_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_IS_MAP,
    C_IS_NOP,
    C_IS_UNMAP,
    C_NOT_PRESENT,
    C_UPPER_MORE,
    C_ENTRY_ZERO,
    C_EXHAUSTED
  } cond_e;

  typedef logic [4:0] step_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uword_t;

  // program addresses
  localparam step_t S_INIT      = 5'd0;
  localparam step_t S_DISP      = 5'd1;
  localparam step_t S_WK_RD     = 5'd2;
  localparam step_t S_WK_CHK    = 5'd3;
  localparam step_t S_WK_ADV    = 5'd4;
  localparam step_t S_LEAF_SEL  = 5'd5;
  localparam step_t S_LEAF_RD   = 5'd6;
  localparam step_t S_LEAF_CHK  = 5'd7;
  localparam step_t S_XLATE     = 5'd8;
  localparam step_t S_UNMAP_WR  = 5'd9;
  localparam step_t S_MAP_RD    = 5'd10;
  localparam step_t S_MAP_CHK   = 5'd11;
  localparam step_t S_MAP_ADV   = 5'd12;
  localparam step_t S_MAP_LEAF  = 5'd13;
  localparam step_t S_MAP_ROOM  = 5'd14;
  localparam step_t S_MAP_ALLOC = 5'd15;
  localparam step_t S_MAP_JMP   = 5'd16;
  localparam step_t S_FAIL_EX   = 5'd17;
  localparam step_t S_FAIL_NT   = 5'd18;
  localparam step_t S_FAIL_NP   = 5'd19;
  localparam step_t S_FIN       = 5'd20;

  // microcode rom: action, jump condition, jump target
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_INIT:      w = '{A_INIT,       C_IS_MAP,      S_MAP_RD};
      S_DISP:      w = '{A_NOP,        C_IS_NOP,      S_FIN};
      S_WK_RD:     w = '{A_READ,       C_NONE,        S_INIT};
      S_WK_CHK:    w = '{A_NOP,        C_NOT_PRESENT, S_FAIL_NT};
      S_WK_ADV:    w = '{A_ADVANCE,    C_UPPER_MORE,  S_WK_RD};
      S_LEAF_SEL:  w = '{A_NOP,        C_IS_UNMAP,    S_UNMAP_WR};
      S_LEAF_RD:   w = '{A_READ,       C_NONE,        S_INIT};
      S_LEAF_CHK:  w = '{A_NOP,        C_NOT_PRESENT, S_FAIL_NP};
      S_XLATE:     w = '{A_SET_ADDR,   C_ALWAYS,      S_FIN};
      S_UNMAP_WR:  w = '{A_WRITE_ZERO, C_ALWAYS,      S_FIN};
      S_MAP_RD:    w = '{A_READ,       C_NONE,        S_INIT};
      S_MAP_CHK:   w = '{A_NOP,        C_ENTRY_ZERO,  S_MAP_ROOM};
      S_MAP_ADV:   w = '{A_ADVANCE,    C_UPPER_MORE,  S_MAP_RD};
      S_MAP_LEAF:  w = '{A_WRITE_LEAF, C_ALWAYS,      S_FIN};
      S_MAP_ROOM:  w = '{A_NOP,        C_EXHAUSTED,   S_FAIL_EX};
      S_MAP_ALLOC: w = '{A_ALLOC,      C_UPPER_MORE,  S_MAP_RD};
      S_MAP_JMP:   w = '{A_NOP,        C_ALWAYS,      S_MAP_LEAF};
      S_FAIL_EX:   w = '{A_SET_EXH,    C_ALWAYS,      S_FIN};
      S_FAIL_NT:   w = '{A_SET_NT,     C_ALWAYS,      S_FIN};
      S_FAIL_NP:   w = '{A_SET_NP,     C_ALWAYS,      S_FIN};
      S_FIN:       w = '{A_FINISH,     C_NONE,        S_INIT};
      default:     w = '{A_FINISH,     C_NONE,        S_INIT};
    endcase
    return w;
  endfunction

  // sequencer to datapath
  typedef struct packed {
    logic load;
    act_e act;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic clearing;
    logic out_free;
    logic is_map;
    logic is_unmap;
    logic is_nop;
    logic present;
    logic entry_zero;
    logic upper_more;
    logic exhausted;
  } dp_flags_t;

endpackage

// ===== rtl/fptw_seq.sv =====
module fptw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fptw_pkg::dp_flags_t flags_i,
  output fptw_pkg::ctl_t      ctl_o
);
  import fptw_pkg::*;

  logic   busy_q, busy_d;
  step_t  step_q, step_d;
  uword_t uw;
  logic   jump;
  logic   hold;
  logic   accept;

  // control word of the current step
  assign uw = ucode(step_q);

  // handshake
  assign in_ready_o = !busy_q && !flags_i.clearing;
  assign accept     = in_valid_i && in_ready_o;
  assign hold       = (uw.act == A_FINISH) && !flags_i.out_free;

  // jump condition
  always_comb begin
    case (uw.cond)
      C_NONE:        jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_IS_MAP:      jump = flags_i.is_map;
      C_IS_NOP:      jump = flags_i.is_nop;
      C_IS_UNMAP:    jump = flags_i.is_unmap;
      C_NOT_PRESENT: jump = !flags_i.present;
      C_UPPER_MORE:  jump = flags_i.upper_more;
      C_ENTRY_ZERO:  jump = flags_i.entry_zero;
      C_EXHAUSTED:   jump = flags_i.exhausted;
      default:       jump = 1'b0;
    endcase
  end

  // step counter and busy flag
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (accept) begin
      busy_d = 1'b1;
      step_d = S_INIT;
    end else if (busy_q) begin
      if (uw.act == A_FINISH) begin
        if (!hold) begin
          busy_d = 1'b0;
        end
      end else if (jump) begin
        step_d = uw.target;
      end else begin
        step_d = step_t'(step_q + step_t'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= S_INIT;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // datapath control
  assign ctl_o.load = accept;
  assign ctl_o.act  = (busy_q && !hold) ? uw.act : A_NOP;

  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= S_FIN)
    else $error("step counter left the program");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && hold) |=> (busy_q && step_q == S_FIN))
    else $error("finish step dropped a result while output was full");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && step_q == S_INIT))
    else $error("accepted word did not start the program");

endmodule

// ===== rtl/fptw_dp.sv =====
module fptw_dp #(
  parameter int TABLE_WORDS = 65536,
  parameter int ALLOC_BYTES = 32768
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fptw_pkg::ctl_t                        ctl_i,
  output fptw_pkg::dp_flags_t                   flags_o,
  input  logic [fptw_pkg::FUNC_W-1:0]           func_i,
  input  logic [fptw_pkg::VA_W-1:0]             virtual_address_i,
  input  logic [fptw_pkg::PA_W-1:0]             physical_address_i,
  input  logic                                  cfg_we_i,
  input  logic [fptw_pkg::CIDX_W-1:0]           cfg_idx_i,
  input  logic [fptw_pkg::CFG_W-1:0]            cfg_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [fptw_pkg::PA_W-1:0]             translated_address_o,
  output logic [1:0]                            status_o
);
  import fptw_pkg::*;

  // word address = table frame bits above the 9-bit index, wrapped to the store
  localparam int AW      = $clog2(TABLE_WORDS);
  localparam int TW      = AW - IDX_W;
  localparam int FRESH_W = $clog2((2 ** CFG_W) + ((2 ** MAXT_W) - 1) * ALLOC_BYTES);

  // configuration
  logic [ROOT_W-1:0] root_q;
  logic [CFG_W-1:0]  pool_q;
  logic [MAXT_W-1:0] maxt_q;
  logic [MAXT_W-1:0] alloc_q;

  // request and walk registers
  logic [FUNC_W-1:0]  func_q;
  logic [VA_W-1:0]    va_q;
  logic [FRAME_W-1:0] pa_q;
  logic [TW-1:0]      tbl_q;
  logic [1:0]         lvl_q;
  logic [PA_W-1:0]    rd_q;
  logic [PA_W-1:0]    res_addr_q;
  status_e            res_st_q;

  // output register
  logic               out_valid_q;
  logic [PA_W-1:0]    out_addr_q;
  status_e            out_st_q;

  // clearing pass
  logic               clearing_q;
  logic [AW-1:0]      clr_q;

  // store
  logic [PA_W-1:0]    mem [TABLE_WORDS];
  logic               we;
  logic [AW-1:0]      waddr;
  logic [PA_W-1:0]    wdata;
  logic               re;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      word_addr;
  logic [FRAME_W-1:0] root_frame;
  logic [FRAME_W-1:0] fresh_frame;
  logic [FRESH_W-1:0] fresh;
  logic [PA_W-1:0]    fresh_entry;
  logic [TW-1:0]      rd_tbl;

  // table index of the current level
  always_comb begin
    case (lvl_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign word_addr  = {tbl_q, idx};
  assign root_frame = FRAME_W'(root_q);
  assign rd_tbl     = rd_q[OFS_W +: TW];

  // next pool table
  assign fresh       = FRESH_W'(pool_q) + FRESH_W'(alloc_q) * FRESH_W'(ALLOC_BYTES);
  assign fresh_frame = FRAME_W'(fresh[FRESH_W-1:OFS_W]);
  assign fresh_entry = {fresh_frame, ENTRY_FLAGS};

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = word_addr;
    wdata = '0;
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_q;
    end else begin
      case (ctl_i.act)
        A_WRITE_ZERO: we = 1'b1;
        A_WRITE_LEAF: begin
          we    = 1'b1;
          wdata = {pa_q, ENTRY_FLAGS};
        end
        A_ALLOC: begin
          we    = 1'b1;
          wdata = fresh_entry;
        end
        default: we = 1'b0;
      endcase
    end
  end

  assign re = (ctl_i.act == A_READ);

  // store, read data registered
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[word_addr];
    end
  end

  // control state, config and pool count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      root_q      <= '0;
      pool_q      <= CFG_W'(4096);
      maxt_q      <= MAXT_W'(15);
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_q <= AW'(clr_q + AW'(1));
        if (clr_q == {AW{1'b1}}) begin
          clearing_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROOT: root_q <= cfg_data_i[CFG_W-1:OFS_W];
          CFG_POOL: pool_q <= cfg_data_i;
          CFG_MAXT: maxt_q <= cfg_data_i[MAXT_W-1:0];
          default:  ;
        endcase
      end
      if (ctl_i.act == A_ALLOC) begin
        alloc_q <= MAXT_W'(alloc_q + MAXT_W'(1));
      end
      if (ctl_i.act == A_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      func_q <= func_i;
      va_q   <= virtual_address_i;
      pa_q   <= physical_address_i[PA_W-1:OFS_W];
    end
    case (ctl_i.act)
      A_INIT: begin
        tbl_q      <= root_frame[TW-1:0];
        lvl_q      <= 2'd0;
        res_st_q   <= ST_OK;
        res_addr_q <= '0;
      end
      A_ADVANCE: begin
        tbl_q <= rd_tbl;
        lvl_q <= 2'(lvl_q + 2'd1);
      end
      A_ALLOC: begin
        tbl_q <= fresh_frame[TW-1:0];
        lvl_q <= 2'(lvl_q + 2'd1);
      end
      A_SET_ADDR: res_addr_q <= {rd_q[PA_W-1:OFS_W], va_q[OFS_W-1:0]};
      A_SET_EXH:  res_st_q   <= ST_EXHAUSTED;
      A_SET_NT:   res_st_q   <= ST_NO_TABLE;
      A_SET_NP:   res_st_q   <= ST_NO_PAGE;
      A_FINISH: begin
        out_addr_q <= res_addr_q;
        out_st_q   <= res_st_q;
      end
      default: ;
    endcase
  end

  // flags for the sequencer
  assign flags_o.clearing   = clearing_q;
  assign flags_o.out_free   = !out_valid_q || out_ready_i;
  assign flags_o.is_map     = (func_q == FN_MAP);
  assign flags_o.is_unmap   = (func_q == FN_UNMAP);
  assign flags_o.is_nop     = !((func_q == FN_TRANSLATE) || (func_q == FN_MAP) ||
                                (func_q == FN_UNMAP));
  assign flags_o.present    = rd_q[PRESENT_BIT];
  assign flags_o.entry_zero = (rd_q == '0);
  assign flags_o.upper_more = (lvl_q != 2'd2);
  assign flags_o.exhausted  = (alloc_q >= maxt_q);

  // outputs
  assign out_valid_o          = out_valid_q;
  assign translated_address_o = out_addr_q;
  assign status_o             = out_st_q;

  a_idle_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (ctl_i.act == A_NOP && !ctl_i.load))
    else $error("datapath active during clearing pass");

  a_alloc_in_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.act == A_ALLOC) |-> (alloc_q < maxt_q))
    else $error("table allocated beyond pool budget");

  a_leaf_write_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.act == A_WRITE_LEAF || ctl_i.act == A_WRITE_ZERO) |-> (lvl_q == 2'd3))
    else $error("leaf entry written above leaf level");

endmodule

// ===== rtl/four_level_page_table_walker_unit.sv =====
// channel  dir  handshake               payload
// in       in   in_valid_i/in_ready_o   func_i, virtual_address_i, physical_address_i
// out      out  out_valid_o/out_ready_i translated_address_o, status_o
// cfg      in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// one word at a time: the run from accept to the next accept is set by the
// microcode program, which spends 3 steps per table level on the single-port store
// (read, check, advance) plus one more step for each newly allocated table
// after reset the store is zeroed one word per cycle over all TABLE_WORDS words;
// in_ready_o stays low until then, config writes are taken throughout
// a finished result waits in the output register; the next word is already taken
// and its last step stalls only if the previous result has not yet been taken
module four_level_page_table_walker_unit #(
  parameter int TABLE_WORDS = 65536,
  parameter int ALLOC_BYTES = 32768
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fptw_pkg::FUNC_W-1:0]     func_i,
  input  logic [fptw_pkg::VA_W-1:0]       virtual_address_i,
  input  logic [fptw_pkg::PA_W-1:0]       physical_address_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fptw_pkg::PA_W-1:0]       translated_address_o,
  output logic [1:0]                      status_o,
  input  logic                            cfg_we_i,
  input  logic [fptw_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  logic [fptw_pkg::CFG_W-1:0]      cfg_data_i
);
  import fptw_pkg::*;

  ctl_t      ctl;
  dp_flags_t flags;

  // microcode sequencer
  fptw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flags_i    (flags),
    .ctl_o      (ctl)
  );

  // walk datapath and table store
  fptw_dp #(
    .TABLE_WORDS (TABLE_WORDS),
    .ALLOC_BYTES (ALLOC_BYTES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctl_i                (ctl),
    .flags_o              (flags),
    .func_i               (func_i),
    .virtual_address_i    (virtual_address_i),
    .physical_address_i   (physical_address_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .translated_address_o (translated_address_o),
    .status_o             (status_o)
  );

endmodule
